@@ hw/rtl/sjhm_pkg.sv @@
package sjhm_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int LIMIT_BITS      = 16;
  localparam int TIME_BITS       = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int OUT_DEPTH       = 2;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd1000;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // Histogram command carried from the front to the back.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_INCR = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  // Width of one queue entry: accepted flag, count, two intervals,
  // two sample extremes, command and histogram address.
  function automatic int entry_bits(input int sample_bits);
    entry_bits = 1 + LIMIT_BITS + 2 * TIME_BITS + 3 * sample_bits + $bits(cmd_t);
  endfunction

endpackage

@@ hw/rtl/sjhm_ram.sv @@
module sjhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sjhm_fifo.sv @@
module sjhm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       full,
  output logic                       empty,
  output logic [WIDTH-1:0]           head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

endmodule

@@ hw/rtl/sjhm_front.sv @@
module sjhm_front #(
  parameter int SAMPLE_BITS = sjhm_pkg::SAMPLE_BITS_DEF,
  parameter int ENTRY_W     = sjhm_pkg::entry_bits(sjhm_pkg::SAMPLE_BITS_DEF)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sjhm_pkg::LIMIT_BITS-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [sjhm_pkg::TIME_BITS-1:0]      timestamp,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic [SAMPLE_BITS-1:0]              bin_index,
  input  logic                                stall,
  output logic                                q_push,
  output logic [ENTRY_W-1:0]                  q_data
);

  typedef struct packed {
    logic                               accepted;
    logic [sjhm_pkg::LIMIT_BITS-1:0]    sample_count;
    logic [sjhm_pkg::TIME_BITS-1:0]     min_interval;
    logic [sjhm_pkg::TIME_BITS-1:0]     max_interval;
    logic [SAMPLE_BITS-1:0]             min_sample;
    logic [SAMPLE_BITS-1:0]             max_sample;
    sjhm_pkg::cmd_t                     cmd;
    logic [SAMPLE_BITS-1:0]             addr;
  } entry_t;

  logic [sjhm_pkg::LIMIT_BITS-1:0] limit;
  logic [sjhm_pkg::TIME_BITS-1:0]  prev_time;
  logic                            have_prev;
  logic [sjhm_pkg::LIMIT_BITS-1:0] rec_count;
  logic [sjhm_pkg::TIME_BITS-1:0]  least_iv;
  logic [sjhm_pkg::TIME_BITS-1:0]  great_iv;
  logic [SAMPLE_BITS-1:0]          least_smp;
  logic [SAMPLE_BITS-1:0]          great_smp;

  logic [sjhm_pkg::LIMIT_BITS-1:0] rec_count_next;
  logic [sjhm_pkg::TIME_BITS-1:0]  least_iv_next;
  logic [sjhm_pkg::TIME_BITS-1:0]  great_iv_next;
  logic [SAMPLE_BITS-1:0]          least_smp_next;
  logic [SAMPLE_BITS-1:0]          great_smp_next;

  logic                            take;
  logic                            record;
  logic [sjhm_pkg::TIME_BITS-1:0]  interval;
  entry_t                          ent;

  assign cfg_ready = 1'b1;
  assign in_ready  = !stall;
  assign take      = in_valid && in_ready;
  assign record    = (op == sjhm_pkg::OP_RECORD) && (rec_count < limit);

  // The timer counts down, so the interval is the older value minus the newer.
  assign interval = prev_time - timestamp;

  always_comb begin
    rec_count_next = rec_count;
    least_iv_next  = least_iv;
    great_iv_next  = great_iv;
    least_smp_next = least_smp;
    great_smp_next = great_smp;
    if (record) begin
      rec_count_next = rec_count + sjhm_pkg::LIMIT_BITS'(1);
      if (have_prev && (interval < least_iv)) begin
        least_iv_next = interval;
      end
      if (have_prev && (interval > great_iv)) begin
        great_iv_next = interval;
      end
      if (sample < least_smp) begin
        least_smp_next = sample;
      end
      if (sample > great_smp) begin
        great_smp_next = sample;
      end
    end
  end

  always_comb begin
    ent.accepted     = record;
    ent.sample_count = rec_count_next;
    ent.min_interval = least_iv_next;
    ent.max_interval = great_iv_next;
    ent.min_sample   = least_smp_next;
    ent.max_sample   = great_smp_next;
    if (op == sjhm_pkg::OP_READ) begin
      ent.cmd  = sjhm_pkg::CMD_READ;
      ent.addr = bin_index;
    end else begin
      ent.cmd  = record ? sjhm_pkg::CMD_INCR : sjhm_pkg::CMD_NONE;
      ent.addr = sample;
    end
  end

  assign q_push = take;
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= sjhm_pkg::LIMIT_RESET;
      prev_time <= '0;
      have_prev <= 1'b0;
      rec_count <= '0;
      least_iv  <= '1;
      great_iv  <= '0;
      least_smp <= '1;
      great_smp <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (take && record) begin
        prev_time <= timestamp;
        have_prev <= 1'b1;
        rec_count <= rec_count_next;
        least_iv  <= least_iv_next;
        great_iv  <= great_iv_next;
        least_smp <= least_smp_next;
        great_smp <= great_smp_next;
      end
    end
  end

endmodule

@@ hw/rtl/sjhm_back.sv @@
module sjhm_back #(
  parameter int SAMPLE_BITS = sjhm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = sjhm_pkg::COUNT_BITS_DEF,
  parameter int ENTRY_W     = sjhm_pkg::entry_bits(sjhm_pkg::SAMPLE_BITS_DEF)
) (
  input  logic                             clk,
  input  logic                             rst,
  output logic                             clearing,
  input  logic                             q_valid,
  input  logic [ENTRY_W-1:0]               q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             accepted,
  output logic [sjhm_pkg::LIMIT_BITS-1:0]  sample_count,
  output logic [sjhm_pkg::TIME_BITS-1:0]   min_interval,
  output logic [sjhm_pkg::TIME_BITS-1:0]   max_interval,
  output logic [sjhm_pkg::TIME_BITS-1:0]   jitter,
  output logic [SAMPLE_BITS-1:0]           min_sample,
  output logic [SAMPLE_BITS-1:0]           max_sample,
  output logic [COUNT_BITS-1:0]            bin_count
);

  localparam int DEPTH = 1 << SAMPLE_BITS;
  localparam int OCW   = $clog2(sjhm_pkg::OUT_DEPTH + 1);

  typedef struct packed {
    logic                               accepted;
    logic [sjhm_pkg::LIMIT_BITS-1:0]    sample_count;
    logic [sjhm_pkg::TIME_BITS-1:0]     min_interval;
    logic [sjhm_pkg::TIME_BITS-1:0]     max_interval;
    logic [SAMPLE_BITS-1:0]             min_sample;
    logic [SAMPLE_BITS-1:0]             max_sample;
    sjhm_pkg::cmd_t                     cmd;
    logic [SAMPLE_BITS-1:0]             addr;
  } entry_t;

  typedef struct packed {
    logic                               accepted;
    logic [sjhm_pkg::LIMIT_BITS-1:0]    sample_count;
    logic [sjhm_pkg::TIME_BITS-1:0]     min_interval;
    logic [sjhm_pkg::TIME_BITS-1:0]     max_interval;
    logic [sjhm_pkg::TIME_BITS-1:0]     jitter;
    logic [SAMPLE_BITS-1:0]             min_sample;
    logic [SAMPLE_BITS-1:0]             max_sample;
    logic [COUNT_BITS-1:0]              bin_count;
  } result_t;

  entry_t                    head;
  entry_t                    infl;
  logic                      infl_valid;
  logic [sjhm_pkg::TIME_BITS-1:0] infl_jitter;
  logic [sjhm_pkg::TIME_BITS-1:0] head_jitter;

  logic [SAMPLE_BITS-1:0]    clr_addr;
  logic                      fwd_valid;
  logic [SAMPLE_BITS-1:0]    fwd_addr;
  logic [COUNT_BITS-1:0]     fwd_data;

  logic                      we;
  logic [SAMPLE_BITS-1:0]    waddr;
  logic [COUNT_BITS-1:0]     wdata;
  logic [COUNT_BITS-1:0]     rdata;
  logic [COUNT_BITS-1:0]     bin_val;

  logic [OCW-1:0]            ocount;
  logic [OCW:0]              occ;
  logic                      opop;
  logic                      ofull;
  logic                      oempty;
  logic                      opush;
  result_t                   res;
  result_t                   ohead;

  assign head = entry_t'(q_data);

  // Issue only when the result buffer is sure to have room in the next cycle.
  assign opop  = out_valid && out_ready;
  assign occ   = {1'b0, ocount} + (OCW + 1)'(infl_valid);
  assign q_pop = q_valid &&
                 ((occ < (OCW + 1)'(sjhm_pkg::OUT_DEPTH)) ||
                  ((occ == (OCW + 1)'(sjhm_pkg::OUT_DEPTH)) && opop));

  assign head_jitter = (head.max_interval >= head.min_interval) ?
                       (head.max_interval - head.min_interval) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      infl_valid <= 1'b0;
    end else begin
      infl_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      infl        <= head;
      infl_jitter <= head_jitter;
    end
  end

  // The write at the edge of the read is not seen by the memory read, so
  // it is forwarded from a copy of the last write.
  assign bin_val = (fwd_valid && (fwd_addr == infl.addr)) ? fwd_data : rdata;

  always_comb begin
    we    = 1'b0;
    waddr = infl.addr;
    wdata = (bin_val == '1) ? bin_val : bin_val + COUNT_BITS'(1);
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (infl_valid && (infl.cmd == sjhm_pkg::CMD_INCR)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + SAMPLE_BITS'(1);
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      fwd_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= waddr;
    fwd_data <= wdata;
  end

  sjhm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head.addr),
    .rdata (rdata)
  );

  always_comb begin
    res.accepted     = infl.accepted;
    res.sample_count = infl.sample_count;
    res.min_interval = infl.min_interval;
    res.max_interval = infl.max_interval;
    res.jitter       = infl_jitter;
    res.min_sample   = infl.min_sample;
    res.max_sample   = infl.max_sample;
    case (infl.cmd)
      sjhm_pkg::CMD_READ: begin
        res.bin_count = bin_val;
      end
      default: begin
        res.bin_count = '0;
      end
    endcase
  end

  // The issue rule above already keeps a full buffer from being pushed
  // unless a beat leaves in the same cycle.
  assign opush = infl_valid && (!ofull || opop);

  sjhm_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (sjhm_pkg::OUT_DEPTH)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (opush),
    .push_data (res),
    .pop       (opop),
    .full      (ofull),
    .empty     (oempty),
    .head      (ohead),
    .count     (ocount)
  );

  assign out_valid    = !oempty;
  assign accepted     = ohead.accepted;
  assign sample_count = ohead.sample_count;
  assign min_interval = ohead.min_interval;
  assign max_interval = ohead.max_interval;
  assign jitter       = ohead.jitter;
  assign min_sample   = ohead.min_sample;
  assign max_sample   = ohead.max_sample;
  assign bin_count    = ohead.bin_count;

endmodule

@@ hw/rtl/sample_jitter_histogram_monitor.sv @@
// A taken beat passes the input queue, in-flight register and result buffer.
// Throughput: one beat per cycle while the queue has room and results drain;
// the histogram read-modify-write forwards the previous cycle's write, so
// back-to-back hits on one bin stay exact. Reset: synchronous, active high;
// afterwards the histogram is swept clear one bin per cycle with in_ready low.
module sample_jitter_histogram_monitor #(
  parameter int SAMPLE_BITS = sjhm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = sjhm_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sjhm_pkg::LIMIT_BITS-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [sjhm_pkg::TIME_BITS-1:0]   timestamp,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic [SAMPLE_BITS-1:0]           bin_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             accepted,
  output logic [sjhm_pkg::LIMIT_BITS-1:0]  sample_count,
  output logic [sjhm_pkg::TIME_BITS-1:0]   min_interval,
  output logic [sjhm_pkg::TIME_BITS-1:0]   max_interval,
  output logic [sjhm_pkg::TIME_BITS-1:0]   jitter,
  output logic [SAMPLE_BITS-1:0]           min_sample,
  output logic [SAMPLE_BITS-1:0]           max_sample,
  output logic [COUNT_BITS-1:0]            bin_count
);

  localparam int ENTRY_W = sjhm_pkg::entry_bits(SAMPLE_BITS);

  logic               clearing;
  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_head;
  logic               q_pop;
  logic [$clog2(sjhm_pkg::QUEUE_DEPTH+1)-1:0] q_count;
  logic               stall;

  assign stall = q_full || clearing;

  sjhm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .timestamp (timestamp),
    .sample    (sample),
    .bin_index (bin_index),
    .stall     (stall),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  sjhm_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (sjhm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head),
    .count     (q_count)
  );

  sjhm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .q_valid      (!q_empty && (q_count != '0)),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .sample_count (sample_count),
    .min_interval (min_interval),
    .max_interval (max_interval),
    .jitter       (jitter),
    .min_sample   (min_sample),
    .max_sample   (max_sample),
    .bin_count    (bin_count)
  );

endmodule

@@ hw/rtl/sjhm_checker.sv @@
module sjhm_checker #(
  parameter int SAMPLE_BITS = sjhm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = sjhm_pkg::COUNT_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [sjhm_pkg::LIMIT_BITS-1:0]  cfg_data,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             op,
  input logic [sjhm_pkg::TIME_BITS-1:0]   timestamp,
  input logic [SAMPLE_BITS-1:0]           sample,
  input logic [SAMPLE_BITS-1:0]           bin_index,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             accepted,
  input logic [sjhm_pkg::LIMIT_BITS-1:0]  sample_count,
  input logic [sjhm_pkg::TIME_BITS-1:0]   min_interval,
  input logic [sjhm_pkg::TIME_BITS-1:0]   max_interval,
  input logic [sjhm_pkg::TIME_BITS-1:0]   jitter,
  input logic [SAMPLE_BITS-1:0]           min_sample,
  input logic [SAMPLE_BITS-1:0]           max_sample,
  input logic [COUNT_BITS-1:0]            bin_count
);

  // A result beat that waits keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_count) &&
    $stable(bin_count) && $stable(jitter) && $stable(accepted))
    else $error("result beat changed while stalled");

  // A recorded sample never reports a bin count.
  a_rec_no_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> bin_count == '0)
    else $error("bin count on a recorded sample");

  a_jitter_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid && (max_interval >= min_interval) |->
    jitter == max_interval - min_interval)
    else $error("jitter is not max minus min interval");

  a_jitter_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (max_interval < min_interval) |-> jitter == '0)
    else $error("jitter nonzero before two samples");

  // The histogram sweep after reset holds off input and output.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block active right after reset");

endmodule

bind sample_jitter_histogram_monitor sjhm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_checker (.*);
